FILE: hdl/dictzip_header_parser_defines.svh
// Assertion macros for the dictzip header parser.
// Each macro checks on the rising edge of clk and is held off during reset.
`ifndef DICTZIP_HEADER_PARSER_DEFINES_SVH
`define DICTZIP_HEADER_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define DZHP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DZHP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DZHP_ASSERT_NOW(label, ante, cons, msg)
`define DZHP_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: hdl/dzhp_pkg.sv
package dzhp_pkg;

    // Header bytes and flag bit positions
    localparam logic [7:0] MAGIC1      = 8'h1f;
    localparam logic [7:0] MAGIC2      = 8'h8b;
    localparam logic [7:0] SUBFIELD_ID1 = 8'h52;  // 'R'
    localparam logic [7:0] SUBFIELD_ID2 = 8'h41;  // 'A'
    localparam int FLG_HCRC    = 1;
    localparam int FLG_EXTRA   = 2;
    localparam int FLG_NAME    = 3;
    localparam int FLG_COMMENT = 4;

    // Advance starting points for the optional header parts
    localparam logic [1:0] ADV_NAME    = 2'd0;
    localparam logic [1:0] ADV_COMMENT = 2'd1;
    localparam logic [1:0] ADV_HCRC    = 2'd2;

    typedef enum logic [4:0] {
        PH_MAG1   = 5'd0,
        PH_MAG2   = 5'd1,
        PH_CM     = 5'd2,
        PH_FLG    = 5'd3,
        PH_MTIME  = 5'd4,
        PH_XFL    = 5'd5,
        PH_OS     = 5'd6,
        PH_XLEN   = 5'd7,
        PH_SI1    = 5'd8,
        PH_SI2    = 5'd9,
        PH_SUBLEN = 5'd10,
        PH_VER    = 5'd11,
        PH_CLEN   = 5'd12,
        PH_CCNT   = 5'd13,
        PH_TABLE  = 5'd14,
        PH_SKIP   = 5'd15,
        PH_NAME   = 5'd16,
        PH_CMT    = 5'd17,
        PH_HCRC   = 5'd18,
        PH_PEND   = 5'd19,
        PH_DONE   = 5'd20
    } phase_t;

    typedef enum logic [2:0] {
        KIND_CHUNK = 3'd0,
        KIND_TEXT  = 3'd1,
        KIND_GZIP  = 3'd2,
        KIND_DZIP  = 3'd3,
        KIND_ZERO  = 3'd4,
        KIND_TRUNC = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] chunk_index;
        logic [15:0] chunk_size;
        logic [31:0] chunk_offset;
        logic [7:0]  method;
        logic [7:0]  flag_bits;
        logic [31:0] mod_time;
        logic [7:0]  os_code;
        logic [15:0] chunk_length;
        logic [15:0] chunk_count;
        logic [31:0] data_start;
    } result_t;

endpackage

FILE: hdl/dzhp_parse.sv
module dzhp_parse
    import dzhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        start_of_file,
    input  logic        end_of_file,
    output logic        res_valid,
    output result_t     res
);

    typedef struct packed {
        phase_t phase;
        logic   ended;
        logic   clr_count;
    } adv_t;

    // Pick the next optional header part at or after the given start
    function automatic adv_t next_part(input logic [1:0] from, input logic [7:0] flg);
        adv_t a;
        a = '{phase: PH_DONE, ended: 1'b0, clr_count: 1'b0};
        if (from == ADV_NAME && flg[FLG_NAME])
            a.phase = PH_NAME;
        else if (from <= ADV_COMMENT && flg[FLG_COMMENT])
            a.phase = PH_CMT;
        else if (from <= ADV_HCRC && flg[FLG_HCRC])
        begin
            a.phase = PH_HCRC;
            a.clr_count = 1'b1;
        end
        else
            a.ended = 1'b1;
        return a;
    endfunction

    phase_t      phase_reg, phase_next, cur_phase;
    logic [1:0]  fbc_reg, fbc_next, cur_fbc;
    logic [31:0] assemble_reg, assemble_next, cur_assemble;
    logic [7:0]  flags_reg, flags_next, cur_flags;
    logic [7:0]  method_reg, method_next, cur_method;
    logic [31:0] mtime_reg, mtime_next, cur_mtime;
    logic [7:0]  os_reg, os_next, cur_os;
    logic [15:0] xrem_reg, xrem_next, cur_xrem;
    logic [15:0] clen_reg, clen_next, cur_clen;
    logic [15:0] ccnt_reg, ccnt_next, cur_ccnt;
    logic [15:0] counter_reg, counter_next, cur_counter;
    logic [31:0] roff_reg, roff_next, cur_roff;
    logic [31:0] bpos_reg, bpos_next, cur_bpos;
    logic        dzip_reg, dzip_next, cur_dzip;

    // Start of file restarts from the reset state
    always_comb
    begin
        if (start_of_file)
        begin
            cur_phase    = PH_MAG1;
            cur_fbc      = '0;
            cur_assemble = '0;
            cur_flags    = '0;
            cur_method   = '0;
            cur_mtime    = '0;
            cur_os       = '0;
            cur_xrem     = '0;
            cur_clen     = '0;
            cur_ccnt     = '0;
            cur_counter  = '0;
            cur_roff     = '0;
            cur_bpos     = '0;
            cur_dzip     = 1'b0;
        end
        else
        begin
            cur_phase    = phase_reg;
            cur_fbc      = fbc_reg;
            cur_assemble = assemble_reg;
            cur_flags    = flags_reg;
            cur_method   = method_reg;
            cur_mtime    = mtime_reg;
            cur_os       = os_reg;
            cur_xrem     = xrem_reg;
            cur_clen     = clen_reg;
            cur_ccnt     = ccnt_reg;
            cur_counter  = counter_reg;
            cur_roff     = roff_reg;
            cur_bpos     = bpos_reg;
            cur_dzip     = dzip_reg;
        end
    end

    logic [15:0] gword;
    logic        gsecond;
    logic        emit_hdr;
    kind_t       hdr_kind;
    logic [31:0] hdr_ds;
    logic        emit_chunk;
    logic        do_adv;
    logic [1:0]  adv_from;
    logic        ended;
    adv_t        adv;

    assign gword   = {data_byte, cur_assemble[7:0]};
    assign gsecond = (cur_fbc != 2'd0);

    // Next state and result for one byte
    always_comb
    begin
        phase_next    = cur_phase;
        fbc_next      = cur_fbc;
        assemble_next = cur_assemble;
        flags_next    = cur_flags;
        method_next   = cur_method;
        mtime_next    = cur_mtime;
        os_next       = cur_os;
        xrem_next     = cur_xrem;
        clen_next     = cur_clen;
        ccnt_next     = cur_ccnt;
        counter_next  = cur_counter;
        roff_next     = cur_roff;
        bpos_next     = cur_bpos;
        dzip_next     = cur_dzip;
        emit_hdr      = 1'b0;
        hdr_kind      = KIND_GZIP;
        hdr_ds        = '0;
        emit_chunk    = 1'b0;
        do_adv        = 1'b0;
        adv_from      = ADV_NAME;
        ended         = 1'b0;
        adv           = '{phase: PH_DONE, ended: 1'b0, clr_count: 1'b0};

        if (cur_phase == PH_DONE)
        begin
            // Ignore bytes until the next start of file
        end
        else if (cur_phase == PH_PEND)
        begin
            // Deliver the final record held back by the last chunk entry
            emit_hdr   = 1'b1;
            hdr_kind   = cur_dzip ? KIND_DZIP : KIND_GZIP;
            hdr_ds     = cur_bpos;
            phase_next = PH_DONE;
        end
        else
        begin
            if (cur_bpos != '1)
                bpos_next = cur_bpos + 32'd1;
            if (cur_phase >= PH_SI1 && cur_phase <= PH_SKIP && cur_xrem != '0)
                xrem_next = cur_xrem - 16'd1;

            case (cur_phase)
                PH_MAG1:
                begin
                    if (data_byte != MAGIC1 || end_of_file)
                    begin
                        emit_hdr   = 1'b1;
                        hdr_kind   = KIND_TEXT;
                        phase_next = PH_DONE;
                    end
                    else
                        phase_next = PH_MAG2;
                end
                PH_MAG2:
                begin
                    if (data_byte != MAGIC2)
                    begin
                        emit_hdr   = 1'b1;
                        hdr_kind   = KIND_TEXT;
                        phase_next = PH_DONE;
                    end
                    else
                        phase_next = PH_CM;
                end
                PH_CM:
                begin
                    method_next = data_byte;
                    phase_next  = PH_FLG;
                end
                PH_FLG:
                begin
                    flags_next    = data_byte;
                    phase_next    = PH_MTIME;
                    fbc_next      = '0;
                    assemble_next = '0;
                end
                PH_MTIME:
                begin
                    assemble_next = cur_assemble | ({24'd0, data_byte} << {cur_fbc, 3'd0});
                    if (cur_fbc == 2'd3)
                    begin
                        mtime_next = assemble_next;
                        fbc_next   = '0;
                        phase_next = PH_XFL;
                    end
                    else
                        fbc_next = cur_fbc + 2'd1;
                end
                PH_XFL:
                    phase_next = PH_OS;
                PH_OS:
                begin
                    os_next  = data_byte;
                    fbc_next = '0;
                    if (cur_flags[FLG_EXTRA])
                        phase_next = PH_XLEN;
                    else
                        do_adv = 1'b1;
                end
                PH_XLEN, PH_SUBLEN, PH_VER, PH_CLEN, PH_CCNT, PH_TABLE, PH_HCRC:
                begin
                    // Two-byte little-endian gather
                    if (!gsecond)
                    begin
                        assemble_next = {24'd0, data_byte};
                        fbc_next      = 2'd1;
                    end
                    else
                    begin
                        fbc_next = '0;
                        case (cur_phase)
                            PH_XLEN:
                            begin
                                xrem_next = gword;
                                if (gword == '0)
                                    do_adv = 1'b1;
                                else
                                    phase_next = PH_SI1;
                            end
                            PH_SUBLEN:
                                phase_next = PH_VER;
                            PH_VER:
                                phase_next = PH_CLEN;
                            PH_CLEN:
                            begin
                                clen_next  = gword;
                                phase_next = PH_CCNT;
                            end
                            PH_CCNT:
                            begin
                                ccnt_next = gword;
                                if (gword == '0)
                                begin
                                    emit_hdr   = 1'b1;
                                    hdr_kind   = KIND_ZERO;
                                    phase_next = PH_DONE;
                                end
                                else
                                begin
                                    counter_next = '0;
                                    roff_next    = '0;
                                    phase_next   = PH_TABLE;
                                end
                            end
                            PH_TABLE:
                            begin
                                emit_chunk   = 1'b1;
                                roff_next    = cur_roff + {16'd0, gword};
                                counter_next = cur_counter + 16'd1;
                                if (counter_next == cur_ccnt)
                                begin
                                    dzip_next = 1'b1;
                                    if (xrem_next != '0)
                                        phase_next = PH_SKIP;
                                    else
                                        do_adv = 1'b1;
                                end
                            end
                            default:
                                ended = 1'b1;
                        endcase
                    end
                end
                PH_SI1:
                begin
                    assemble_next = {24'd0, data_byte};
                    if (xrem_next == '0)
                        do_adv = 1'b1;
                    else
                        phase_next = PH_SI2;
                end
                PH_SI2:
                begin
                    if (cur_assemble[7:0] == SUBFIELD_ID1 && data_byte == SUBFIELD_ID2)
                    begin
                        phase_next = PH_SUBLEN;
                        fbc_next   = '0;
                    end
                    else if (xrem_next == '0)
                        do_adv = 1'b1;
                    else
                        phase_next = PH_SKIP;
                end
                PH_SKIP:
                begin
                    if (xrem_next == '0)
                        do_adv = 1'b1;
                end
                PH_NAME:
                begin
                    if (data_byte == 8'd0)
                    begin
                        do_adv   = 1'b1;
                        adv_from = ADV_COMMENT;
                    end
                end
                PH_CMT:
                begin
                    if (data_byte == 8'd0)
                    begin
                        do_adv   = 1'b1;
                        adv_from = ADV_HCRC;
                    end
                end
                default:
                    phase_next = PH_DONE;
            endcase

            // Move on to the next optional part
            if (do_adv)
            begin
                adv = next_part(adv_from, flags_next);
                if (adv.ended)
                    ended = 1'b1;
                else
                    phase_next = adv.phase;
                if (adv.clr_count)
                    fbc_next = '0;
            end

            // Header end: hold the record back one byte behind a chunk entry
            if (ended)
            begin
                if (emit_chunk)
                    phase_next = PH_PEND;
                else
                begin
                    emit_hdr   = 1'b1;
                    hdr_kind   = dzip_next ? KIND_DZIP : KIND_GZIP;
                    hdr_ds     = bpos_next;
                    phase_next = PH_DONE;
                end
            end

            // Truncation overrides anything else unless this byte already ends the parse
            if (end_of_file && phase_next != PH_DONE)
            begin
                emit_hdr   = 1'b1;
                emit_chunk = 1'b0;
                hdr_kind   = KIND_TRUNC;
                hdr_ds     = '0;
                phase_next = PH_DONE;
            end
        end
    end

    // Build the result record
    always_comb
    begin
        res       = '0;
        res.kind  = KIND_CHUNK;
        res_valid = emit_hdr || emit_chunk;
        if (emit_chunk)
        begin
            res.chunk_index  = cur_counter;
            res.chunk_size   = gword;
            res.chunk_offset = cur_roff;
        end
        else if (emit_hdr)
        begin
            res.kind         = hdr_kind;
            res.method       = method_next;
            res.flag_bits    = flags_next;
            res.mod_time     = mtime_next;
            res.os_code      = os_next;
            res.chunk_length = clen_next;
            res.chunk_count  = ccnt_next;
            res.data_start   = hdr_ds;
        end
    end

    // Advance the parser state on every accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_MAG1;
            fbc_reg      <= '0;
            assemble_reg <= '0;
            flags_reg    <= '0;
            method_reg   <= '0;
            mtime_reg    <= '0;
            os_reg       <= '0;
            xrem_reg     <= '0;
            clen_reg     <= '0;
            ccnt_reg     <= '0;
            counter_reg  <= '0;
            roff_reg     <= '0;
            bpos_reg     <= '0;
            dzip_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            fbc_reg      <= fbc_next;
            assemble_reg <= assemble_next;
            flags_reg    <= flags_next;
            method_reg   <= method_next;
            mtime_reg    <= mtime_next;
            os_reg       <= os_next;
            xrem_reg     <= xrem_next;
            clen_reg     <= clen_next;
            ccnt_reg     <= ccnt_next;
            counter_reg  <= counter_next;
            roff_reg     <= roff_next;
            bpos_reg     <= bpos_next;
            dzip_reg     <= dzip_next;
        end
    end

endmodule

FILE: hdl/dzhp_out_reg.sv
module dzhp_out_reg
    import dzhp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    input  logic    out_ready,
    output logic    out_valid,
    output logic    free,
    output result_t out_data
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    // Slot is free when empty or draining this cycle
    assign free = !valid_reg || out_ready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Hold the payload until the transfer completes
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: hdl/dictzip_header_parser.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready   | data_byte, start_of_file, end_of_file
// out     | output    | out_valid/out_ready | kind, chunk_*, method, flag_bits, mod_time,
//         |           |                    | os_code, chunk_length, chunk_count, data_start
//
// One byte per cycle while in_ready is high: the parser state register updates on each
// transfer and any result lands in a single output register in the same cycle.
// in_ready is high while the output register is empty or is being drained.
// A stall on out with a result waiting holds off the input.
// Reset clears the parser to expect the first magic byte; no clearing pass.
`include "dictzip_header_parser_defines.svh"

module dictzip_header_parser
    import dzhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_of_file,
    input  logic        end_of_file,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [15:0] chunk_index,
    output logic [15:0] chunk_size,
    output logic [31:0] chunk_offset,
    output logic [7:0]  method,
    output logic [7:0]  flag_bits,
    output logic [31:0] mod_time,
    output logic [7:0]  os_code,
    output logic [15:0] chunk_length,
    output logic [15:0] chunk_count,
    output logic [31:0] data_start
);

    logic    accept;
    logic    res_valid;
    result_t res;
    result_t out_data;
    logic    slot_free;

    assign in_ready = slot_free;
    assign accept   = in_valid && in_ready;

    dzhp_parse u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (accept),
        .data_byte     (data_byte),
        .start_of_file (start_of_file),
        .end_of_file   (end_of_file),
        .res_valid     (res_valid),
        .res           (res)
    );

    dzhp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && res_valid),
        .load_data (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .free      (slot_free),
        .out_data  (out_data)
    );

    // Unpack the result record onto the ports
    assign kind         = out_data.kind;
    assign chunk_index  = out_data.chunk_index;
    assign chunk_size   = out_data.chunk_size;
    assign chunk_offset = out_data.chunk_offset;
    assign method       = out_data.method;
    assign flag_bits    = out_data.flag_bits;
    assign mod_time     = out_data.mod_time;
    assign os_code      = out_data.os_code;
    assign chunk_length = out_data.chunk_length;
    assign chunk_count  = out_data.chunk_count;
    assign data_start   = out_data.data_start;

    `DZHP_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")
    `DZHP_ASSERT_NEXT(a_result_loaded, accept && res_valid, out_valid, "result lost after transfer")
    `DZHP_ASSERT_NEXT(a_drain_clears, out_valid && out_ready && !(accept && res_valid), !out_valid, "result repeated after transfer")
    `DZHP_ASSERT_NOW(a_chunk_no_header, out_valid && kind == KIND_CHUNK, data_start == 32'd0 && method == 8'd0, "chunk entry carries header fields")

endmodule
